// ----- rtl/sine_rgb_gradient_generator_macros.svh -----
// ============================================================================
// Assertion macros for the sine RGB gradient generator
// Concurrent check shorthands used by the checker file srgg_checker.sv.
// ============================================================================
`ifndef SINE_RGB_GRADIENT_GENERATOR_MACROS_SVH
`define SINE_RGB_GRADIENT_GENERATOR_MACROS_SVH

// same-cycle implication
`define SRGG_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SRGG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/srgg_pkg.sv -----
// ============================================================================
// srgg_pkg
// Types, constants and the sine table builder of the gradient generator.
// ============================================================================
package srgg_pkg;

	localparam int unsigned IDX_W     = 6;
	localparam int unsigned ANGLE_W   = 16;
	localparam int unsigned LEVEL_W   = 8;
	localparam int unsigned SINE_W    = 16;
	localparam int unsigned ROM_AW    = 10;
	localparam int unsigned ROM_DEPTH = 1 << ROM_AW;
	localparam int unsigned QUARTER   = ROM_DEPTH / 4;
	localparam int unsigned PROD_W    = 24;
	localparam int unsigned APB_AW    = 5;
	localparam int unsigned APB_DW    = 32;

	// register map, word index
	typedef enum logic [2:0] {
		REG_RED_STEP     = 3'd0,
		REG_GREEN_STEP   = 3'd1,
		REG_BLUE_STEP    = 3'd2,
		REG_RED_OFFSET   = 3'd3,
		REG_GREEN_OFFSET = 3'd4,
		REG_BLUE_OFFSET  = 3'd5,
		REG_CENTER       = 3'd6,
		REG_AMPLITUDE    = 3'd7
	} srgg_reg_t;

	localparam logic [ANGLE_W-1:0] RST_RED_STEP     = 16'd1043;
	localparam logic [ANGLE_W-1:0] RST_GREEN_STEP   = 16'd1043;
	localparam logic [ANGLE_W-1:0] RST_BLUE_STEP    = 16'd1043;
	localparam logic [ANGLE_W-1:0] RST_RED_OFFSET   = 16'd0;
	localparam logic [ANGLE_W-1:0] RST_GREEN_OFFSET = 16'd20861;
	localparam logic [ANGLE_W-1:0] RST_BLUE_OFFSET  = 16'd41722;
	localparam logic [LEVEL_W-1:0] RST_CENTER       = 8'd128;
	localparam logic [LEVEL_W-1:0] RST_AMPLITUDE    = 8'd127;

	typedef struct packed {
		logic [ANGLE_W-1:0] red_step;
		logic [ANGLE_W-1:0] green_step;
		logic [ANGLE_W-1:0] blue_step;
		logic [ANGLE_W-1:0] red_offset;
		logic [ANGLE_W-1:0] green_offset;
		logic [ANGLE_W-1:0] blue_offset;
		logic [LEVEL_W-1:0] center_level;
		logic [LEVEL_W-1:0] amplitude;
	} srgg_cfg_t;

	// per-stage load enables, stage k loads when its slot is free
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} srgg_adv_t;

	typedef logic signed [SINE_W-1:0] srgg_rom_t [ROM_DEPTH];

	// pi/2 in Q62
	localparam logic [63:0] Q62_HALF_PI = 64'h6487ED5110B4611A;
	localparam logic [63:0] HALF_PI_HI  = Q62_HALF_PI / 256;
	localparam logic [63:0] HALF_PI_LO  = Q62_HALF_PI % 256;

	// shift-subtract quotient, used only while building the table
	function automatic logic [63:0] srgg_udiv(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// round(32767*sin(k*pi/512)) for k in 0..QUARTER, Taylor series in Q62
	function automatic logic signed [SINE_W-1:0] srgg_quarter_sine(input int unsigned k);
		logic [63:0]  kk;
		logic [63:0]  x;
		logic [63:0]  x2;
		logic [63:0]  term;
		logic [63:0]  sum;
		logic [63:0]  den;
		logic [127:0] p;
		logic [63:0]  r;
		logic         neg;
		kk   = 64'(k);
		x    = HALF_PI_HI * kk + ((HALF_PI_LO * kk) >> 8);
		p    = 128'(x) * 128'(x);
		x2   = p[125:62];
		term = x;
		sum  = x;
		neg  = 1'b1;
		// terms alternate in sign, starting with x^3 subtracted
		for (int n = 3; n <= 27; n += 2) begin
			p    = 128'(term) * 128'(x2);
			den  = 64'((n - 1) * n);
			term = srgg_udiv(p[125:62], den);
			if (neg)
				sum = sum - term;
			else
				sum = sum + term;
			neg = ~neg;
		end
		r = (((sum >> 22) * 64'd32767) + (64'd1 << 39)) >> 40;
		return SINE_W'(r);
	endfunction

	function automatic srgg_rom_t srgg_build_rom();
		logic signed [SINE_W-1:0] q [QUARTER+1];
		srgg_rom_t rom;
		for (int unsigned k = 0; k <= QUARTER; k++)
			q[k] = srgg_quarter_sine(k);
		for (int unsigned k = 0; k < ROM_DEPTH; k++) begin
			if (k <= QUARTER)
				rom[k] = q[k];
			else if (k <= 2 * QUARTER)
				rom[k] = q[2 * QUARTER - k];
			else if (k <= 3 * QUARTER)
				rom[k] = -q[k - 2 * QUARTER];
			else
				rom[k] = -q[ROM_DEPTH - k];
		end
		return rom;
	endfunction

endpackage

// ----- rtl/sine_rgb_gradient_generator.sv -----
// ============================================================================
// sine_rgb_gradient_generator
// Maps a gradient index to an RGB color from three phase-shifted sine waves.
// ============================================================================
//
//  channel  | signals                                   | moves
//  ---------+-------------------------------------------+------------------------
//  input    | in_valid, in_ready, index                 | one index per transfer
//  output   | out_valid, out_ready, red/green/blue/refused | one color per transfer
//  config   | psel, penable, pwrite, paddr, pwdata, prdata | APB register access
//
//  One index per clock sustained while out_ready holds; each transfer is registered
//  through phase multiply-add, sine ROM read, amplitude multiply and clamp stages.
//  Every stage holds its own valid bit and loads when free, so bubbles fill
//  even while the output waits; a stall at the output backs up stage by stage.
//  arst_n clears the valid bits and loads the register reset values.
//
module sine_rgb_gradient_generator
	import srgg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// index input
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [IDX_W-1:0]   index,
	// color output
	output logic               out_valid,
	input  logic               out_ready,
	output logic [LEVEL_W-1:0] red,
	output logic [LEVEL_W-1:0] green,
	output logic [LEVEL_W-1:0] blue,
	output logic               refused,
	// APB config
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready
);

	srgg_cfg_t cfg;
	srgg_adv_t adv;
	logic      v_s1, v_s2, v_s3, v_s4;
	logic      refused_now;
	logic      refused_s4;

	assign pready = 1'b1;

	srgg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// a stage is free when empty or when the stage after it is moving
	always_comb begin
		adv.s4 = !v_s4 || out_ready;
		adv.s3 = !v_s3 || adv.s4;
		adv.s2 = !v_s2 || adv.s3;
		adv.s1 = !v_s1 || adv.s2;
	end

	assign in_ready = adv.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv.s1)
				v_s1 <= in_valid;
			if (adv.s2)
				v_s2 <= v_s1;
			if (adv.s3)
				v_s3 <= v_s2;
			if (adv.s4)
				v_s4 <= v_s3;
		end
	end

	// user holds config static while items are in flight (unenforced); refusal at s4
	assign refused_now = (cfg.center_level == '0) || (cfg.amplitude == '0);

	always_ff @(posedge clk) begin
		if (adv.s4)
			refused_s4 <= refused_now;
	end

	srgg_lane u_red (
		.clk          (clk),
		.adv          (adv),
		.index        (index),
		.step         (cfg.red_step),
		.offset       (cfg.red_offset),
		.center_level (cfg.center_level),
		.amplitude    (cfg.amplitude),
		.refused      (refused_now),
		.level        (red)
	);

	srgg_lane u_green (
		.clk          (clk),
		.adv          (adv),
		.index        (index),
		.step         (cfg.green_step),
		.offset       (cfg.green_offset),
		.center_level (cfg.center_level),
		.amplitude    (cfg.amplitude),
		.refused      (refused_now),
		.level        (green)
	);

	srgg_lane u_blue (
		.clk          (clk),
		.adv          (adv),
		.index        (index),
		.step         (cfg.blue_step),
		.offset       (cfg.blue_offset),
		.center_level (cfg.center_level),
		.amplitude    (cfg.amplitude),
		.refused      (refused_now),
		.level        (blue)
	);

	assign out_valid = v_s4;
	assign refused   = refused_s4;

endmodule

// ----- rtl/srgg_regs.sv -----
// ============================================================================
// srgg_regs
// APB register file holding phase steps, offsets, center and amplitude.
// ============================================================================
module srgg_regs
	import srgg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output srgg_cfg_t         cfg
);

	srgg_cfg_t cfg_q;
	srgg_reg_t sel;
	logic      wr_en;

	assign sel   = srgg_reg_t'(paddr[APB_AW-1:2]);
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red_step     <= RST_RED_STEP;
			cfg_q.green_step   <= RST_GREEN_STEP;
			cfg_q.blue_step    <= RST_BLUE_STEP;
			cfg_q.red_offset   <= RST_RED_OFFSET;
			cfg_q.green_offset <= RST_GREEN_OFFSET;
			cfg_q.blue_offset  <= RST_BLUE_OFFSET;
			cfg_q.center_level <= RST_CENTER;
			cfg_q.amplitude    <= RST_AMPLITUDE;
		end else if (wr_en) begin
			case (sel)
				REG_RED_STEP:     cfg_q.red_step     <= pwdata[ANGLE_W-1:0];
				REG_GREEN_STEP:   cfg_q.green_step   <= pwdata[ANGLE_W-1:0];
				REG_BLUE_STEP:    cfg_q.blue_step    <= pwdata[ANGLE_W-1:0];
				REG_RED_OFFSET:   cfg_q.red_offset   <= pwdata[ANGLE_W-1:0];
				REG_GREEN_OFFSET: cfg_q.green_offset <= pwdata[ANGLE_W-1:0];
				REG_BLUE_OFFSET:  cfg_q.blue_offset  <= pwdata[ANGLE_W-1:0];
				REG_CENTER:       cfg_q.center_level <= pwdata[LEVEL_W-1:0];
				REG_AMPLITUDE:    cfg_q.amplitude    <= pwdata[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			REG_RED_STEP:     prdata = APB_DW'(cfg_q.red_step);
			REG_GREEN_STEP:   prdata = APB_DW'(cfg_q.green_step);
			REG_BLUE_STEP:    prdata = APB_DW'(cfg_q.blue_step);
			REG_RED_OFFSET:   prdata = APB_DW'(cfg_q.red_offset);
			REG_GREEN_OFFSET: prdata = APB_DW'(cfg_q.green_offset);
			REG_BLUE_OFFSET:  prdata = APB_DW'(cfg_q.blue_offset);
			REG_CENTER:       prdata = APB_DW'(cfg_q.center_level);
			REG_AMPLITUDE:    prdata = APB_DW'(cfg_q.amplitude);
			default:          prdata = '0;
		endcase
	end

endmodule

// ----- rtl/srgg_lane.sv -----
// ============================================================================
// srgg_lane
// One color channel: phase, sine ROM, amplitude scale, center add and clamp.
// ============================================================================
module srgg_lane
	import srgg_pkg::*;
(
	input  logic               clk,
	input  srgg_adv_t          adv,
	input  logic [IDX_W-1:0]   index,
	input  logic [ANGLE_W-1:0] step,
	input  logic [ANGLE_W-1:0] offset,
	input  logic [LEVEL_W-1:0] center_level,
	input  logic [LEVEL_W-1:0] amplitude,
	input  logic               refused,
	output logic [LEVEL_W-1:0] level
);

	localparam srgg_rom_t SINE_ROM = srgg_build_rom();

	logic        [ANGLE_W-1:0] angle;
	logic        [ROM_AW-1:0]  addr_s1;
	logic signed [SINE_W-1:0]  sine_s2;
	logic signed [PROD_W-1:0]  prod;
	logic signed [PROD_W-1:0]  prod_s3;
	logic signed [LEVEL_W:0]   scaled;
	logic signed [LEVEL_W+1:0] sum;
	logic        [LEVEL_W-1:0] sat;
	logic        [LEVEL_W-1:0] level_s4;

	// angle wraps mod one turn
	assign angle = step * ANGLE_W'(index) + offset;
	assign prod  = sine_s2 * $signed({1'b0, amplitude});

	// floor(prod / 32768) then center add and clamp to 0..255
	assign scaled = (LEVEL_W+1)'(prod_s3 >>> (SINE_W - 1));
	assign sum    = $signed({2'b00, center_level}) + (LEVEL_W+2)'(scaled);

	always_comb begin
		if (sum < 0)
			sat = '0;
		else if (sum > $signed((LEVEL_W+2)'((1 << LEVEL_W) - 1)))
			sat = '1;
		else
			sat = sum[LEVEL_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv.s1)
			addr_s1 <= angle[ANGLE_W-1 -: ROM_AW];
		if (adv.s2)
			sine_s2 <= SINE_ROM[addr_s1];
		if (adv.s3)
			prod_s3 <= prod;
		if (adv.s4)
			level_s4 <= refused ? '0 : sat;
	end

	assign level = level_s4;

endmodule

// ----- rtl/srgg_checker.sv -----
// ============================================================================
// srgg_checker
// Port-level checks on the gradient generator, bound to the top level.
// ============================================================================
`include "sine_rgb_gradient_generator_macros.svh"

module srgg_checker
	import srgg_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [LEVEL_W-1:0] red,
	input logic [LEVEL_W-1:0] green,
	input logic [LEVEL_W-1:0] blue,
	input logic               refused
);

	// stalled result holds
	`SRGG_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable({red, green, blue, refused}), "output changed while stalled")

	// refused color is black
	`SRGG_ASSERT_IMPLY(a_refused_black, clk, arst_n, out_valid && refused, red == '0 && green == '0 && blue == '0, "refused result carries color")

	// a draining output frees the whole pipe
	`SRGG_ASSERT_IMPLY(a_ready_chain, clk, arst_n, out_ready, in_ready, "input stalled while output drains")

endmodule

bind sine_rgb_gradient_generator srgg_checker u_srgg_checker (.*);
